@@ hdl/unsorted_array_priority_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// unsorted array priority queue - assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define UPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define UPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/upq_pkg.sv @@
// ----------------------------------------------------------------------------
// upq_pkg
// types and codes shared by the priority queue top level and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package upq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic occupied;
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

  // running minimum handed along the chain
  typedef struct packed {
    logic [7:0]         prio;
    logic signed [31:0] value;
  } carry_t;

endpackage

`default_nettype wire

@@ hdl/upq_cell.sv @@
// ----------------------------------------------------------------------------
// upq_cell
// one queue slot: holds a pair, shifts from its right neighbor on remove and
// forwards the running minimum of the slots to its left one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module upq_cell
  import upq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned POS_W = 3
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] wr_value,
  input  logic [7:0]         wr_priority,
  input  logic signed [31:0] nbr_value,
  input  logic [7:0]         nbr_priority,
  input  carry_t             carry_in,
  input  logic [POS_W-1:0]   carry_pos_in,
  output logic signed [31:0] st_value,
  output logic [7:0]         st_priority,
  output carry_t             carry_out,
  output logic [POS_W-1:0]   carry_pos_out
);

  localparam bit                 FIRST  = (IDX == 0);
  localparam logic [POS_W-1:0]   OWN_POS = POS_W'(IDX);

  logic signed [31:0] value_r, value_nxt;
  logic [7:0]         priority_r, priority_nxt;
  carry_t             carry_r, carry_nxt;
  logic [POS_W-1:0]   carry_pos_r, carry_pos_nxt;
  logic               take_own;

  always_comb begin
    value_nxt    = value_r;
    priority_nxt = priority_r;
    if (ctrl.wr_en) begin
      value_nxt    = wr_value;
      priority_nxt = wr_priority;
    end else if (ctrl.shift_en) begin
      value_nxt    = nbr_value;
      priority_nxt = nbr_priority;
    end
  end

  // strict compare keeps the earliest slot on ties
  assign take_own = ctrl.occupied && (FIRST || (priority_r < carry_in.prio));

  always_comb begin
    if (take_own) begin
      carry_nxt.prio  = priority_r;
      carry_nxt.value = value_r;
      carry_pos_nxt   = OWN_POS;
    end else begin
      carry_nxt     = carry_in;
      carry_pos_nxt = carry_pos_in;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    priority_r  <= priority_nxt;
    carry_r     <= carry_nxt;
    carry_pos_r <= carry_pos_nxt;
  end

  assign st_value      = value_r;
  assign st_priority   = priority_r;
  assign carry_out     = carry_r;
  assign carry_pos_out = carry_pos_r;

endmodule

`default_nettype wire

@@ hdl/unsorted_array_priority_queue_core.sv @@
// Priority queue of up to DEPTH (value, priority) pairs kept in arrival order
// in a chain of slot cells. An insert is latched by the sequencer and committed
// from there to the output register. A remove first lets the running minimum walk
// the cell chain one cell per clock up to the last occupied slot (no walk for an
// empty queue), after which all later pairs shift down together. One word is worked
// on at a time; a result waits in the output register while stalled.
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_core
// top level: sequencer, cell chain, minimum pickup and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsorted_array_priority_queue_core_macros.svh"

module unsorted_array_priority_queue_core
  import upq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [31:0] in_item_value,
  input  logic [7:0]         in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [7:0]         out_removed_priority,
  output logic [2:0]         out_removed_position,
  output logic [3:0]         out_occupancy
);

  localparam int unsigned POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic               cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [7:0]         pri_r, pri_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] rvalue_r, rvalue_nxt;
  logic [7:0]         rprio_r, rprio_nxt;
  logic [2:0]         rpos_r, rpos_nxt;
  logic [3:0]         occ_r, occ_nxt;

  logic               accept, out_free, commit, commit_ins, commit_rem;
  logic [CNT_W-1:0]   last_idx;
  carry_t             sel_carry;
  logic [POS_W-1:0]   sel_pos;

  cell_ctrl_t         ctrl     [DEPTH];
  logic signed [31:0] st_value [DEPTH];
  logic [7:0]         st_prio  [DEPTH];
  logic signed [31:0] nb_value [DEPTH];
  logic [7:0]         nb_prio  [DEPTH];
  carry_t             carry    [DEPTH];
  logic [POS_W-1:0]   cpos     [DEPTH];
  carry_t             cin      [DEPTH];
  logic [POS_W-1:0]   cpin     [DEPTH];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // insert is ready at once, remove once the minimum has reached the last slot; both need a free output register
  assign commit     = (state_r == S_BUSY) && ((cmd_r == CMD_INSERT) || (cnt_r == '0))
                      && out_free;
  assign commit_ins = commit && (cmd_r == CMD_INSERT);
  assign commit_rem = commit && (cmd_r == CMD_REMOVE) && (count_r != '0);

  assign last_idx = count_r - 1'b1;

  // pick up the chain's minimum at the last occupied slot
  always_comb begin
    sel_carry = '0;
    sel_pos   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) == last_idx) begin
        sel_carry = sel_carry | carry[i];
        sel_pos   = sel_pos | cpos[i];
      end
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX_C = CNT_W'(i);
      localparam logic [POS_W-1:0] IDX_P = POS_W'(i);

      assign ctrl[i].occupied = (IDX_C < count_r);
      assign ctrl[i].wr_en    = commit_ins && (count_r == IDX_C);
      assign ctrl[i].shift_en = commit_rem && (IDX_P >= sel_pos);

      if (i == 0) begin : g_head
        assign cin[i]  = '0;
        assign cpin[i] = '0;
      end else begin : g_link
        assign cin[i]  = carry[i-1];
        assign cpin[i] = cpos[i-1];
      end

      // the last slot has no right neighbor and just holds on a shift
      if (i == DEPTH - 1) begin : g_tail
        assign nb_value[i] = st_value[i];
        assign nb_prio[i]  = st_prio[i];
      end else begin : g_next
        assign nb_value[i] = st_value[i+1];
        assign nb_prio[i]  = st_prio[i+1];
      end

      upq_cell #(
        .IDX   (i),
        .POS_W (POS_W)
      ) u_cell (
        .clk           (clk),
        .ctrl          (ctrl[i]),
        .wr_value      (val_r),
        .wr_priority   (pri_r),
        .nbr_value     (nb_value[i]),
        .nbr_priority  (nb_prio[i]),
        .carry_in      (cin[i]),
        .carry_pos_in  (cpin[i]),
        .st_value      (st_value[i]),
        .st_priority   (st_prio[i]),
        .carry_out     (carry[i]),
        .carry_pos_out (cpos[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    pri_nxt   = pri_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BUSY;
          cmd_nxt   = in_command;
          val_nxt   = in_item_value;
          pri_nxt   = in_item_priority;
          cnt_nxt   = (count_r == '0) ? '0 : POS_W'(count_r - 1'b1);
        end
      end
      S_BUSY: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        if (commit) begin
          state_nxt = S_IDLE;
          if (commit_ins && (count_r != DEPTH_C)) begin
            count_nxt = count_r + 1'b1;
          end else if (commit_rem) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    rvalue_nxt    = rvalue_r;
    rprio_nxt     = rprio_r;
    rpos_nxt      = rpos_r;
    occ_nxt       = occ_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      if (cmd_r == CMD_INSERT) begin
        status_nxt = (count_r == DEPTH_C) ? ST_FULL : ST_DONE;
      end else begin
        status_nxt = (count_r == '0) ? ST_EMPTY : ST_DONE;
      end
      rvalue_nxt = commit_rem ? sel_carry.value : '0;
      rprio_nxt  = commit_rem ? sel_carry.prio : '0;
      rpos_nxt   = commit_rem ? 3'(sel_pos) : '0;
      occ_nxt    = 4'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    pri_r    <= pri_nxt;
    status_r <= status_nxt;
    rvalue_r <= rvalue_nxt;
    rprio_r  <= rprio_nxt;
    rpos_r   <= rpos_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_value    = rvalue_r;
  assign out_removed_priority = rprio_r;
  assign out_removed_position = rpos_r;
  assign out_occupancy        = occ_r;

  `UPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r == S_BUSY, "accepted word did not start work")
  `UPQ_ASSERT_NEXT(a_remove_count, clk, rst_n, commit_rem, count_r == CNT_W'($past(count_r) - 1'b1), "remove did not drop the count by one")
  `UPQ_ASSERT_SAME(a_pick_in_range, clk, rst_n, commit_rem, CNT_W'(sel_pos) < count_r, "picked slot lies beyond the stored pairs")
  `UPQ_ASSERT_SAME(a_empty_occ, clk, rst_n, out_valid_r && (status_r == ST_EMPTY), occ_r == '0, "empty status with nonzero occupancy")

endmodule

`default_nettype wire

@@ tb/unsorted_array_priority_queue_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_core_tb
// drives insert and remove words into the priority queue core, mirrors the
// queue contents in a local predictor and checks every result word in order,
// with random gaps and stalls on both channels, one long output hold-off and
// two pauses until the queue core has drained
// ----------------------------------------------------------------------------

module unsorted_array_priority_queue_core_tb;
  import upq_pkg::*;

  localparam int DEPTH       = 8;
  localparam int RAND_WORDS  = 2000;
  localparam int LONG_AT     = 1000;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic               cmd;
    logic signed [31:0] value;
    logic [7:0]         prio;
    int                 gap;
    bit                 hold;
  } pq_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [7:0]         prio;
    logic [2:0]         pos;
    logic [3:0]         occ;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = CMD_INSERT;
  logic signed [31:0] in_item_value = '0;
  logic [7:0]         in_item_priority = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_removed_value;
  logic [7:0]         out_removed_priority;
  logic [2:0]         out_removed_position;
  logic [3:0]         out_occupancy;

  pq_word_t pend_q[$];
  outcome_t outcome_q[$];

  // predictor copy of the queue contents
  logic signed [31:0] mirror_value[DEPTH];
  logic [7:0]         mirror_prio[DEPTH];
  int                 mirror_count = 0;

  int n_sent = 0;
  int n_done = 0;
  int n_errors = 0;
  int n_removed = 0;
  int n_full = 0;
  int n_empty = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  pq_word_t cur;

  unsorted_array_priority_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_item_value       (in_item_value),
    .in_item_priority    (in_item_priority),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_removed_value   (out_removed_value),
    .out_removed_priority(out_removed_priority),
    .out_removed_position(out_removed_position),
    .out_occupancy       (out_occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t predict_outcome(input logic cmd, input logic signed [31:0] v,
                                               input logic [7:0] p);
    outcome_t o;
    int best;
    o = '0;
    o.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (mirror_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        mirror_value[mirror_count] = v;
        mirror_prio[mirror_count] = p;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // earliest pair wins on equal priority
      best = 0;
      for (int k = 1; k < mirror_count; k++) begin
        if (mirror_prio[k] < mirror_prio[best]) best = k;
      end
      o.value = mirror_value[best];
      o.prio = mirror_prio[best];
      o.pos = best[2:0];
      for (int k = best; k < mirror_count - 1; k++) begin
        mirror_value[k] = mirror_value[k + 1];
        mirror_prio[k] = mirror_prio[k + 1];
      end
      mirror_count--;
    end
    o.occ = mirror_count[3:0];
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: result %0d %s got %0h want %0h", $time, n_done, what, got, want);
    n_errors++;
  endtask

  task automatic add_word(input logic cmd, input logic signed [31:0] v, input logic [7:0] p,
                          input int gap, input bit hold);
    pq_word_t w;
    w.cmd = cmd;
    w.value = v;
    w.prio = p;
    w.gap = gap;
    w.hold = hold;
    pend_q.push_back(w);
  endtask

  // sender: offers queued words, idles between them, holds on a pause mark
  always @(posedge clk) begin
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_command <= CMD_INSERT;
      in_item_value <= '0;
      in_item_priority <= '0;
      gap_left = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        outcome_q.push_back(predict_outcome(cur.cmd, cur.value, cur.prio));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0 && !(pend_q[0].hold && (n_sent + took) != n_done)) begin
          cur = pend_q.pop_front();
          in_command <= cur.cmd;
          in_item_value <= cur.value;
          in_item_priority <= cur.prio;
          in_valid <= 1'b1;
          gap_left = cur.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result word, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("unexpected word", 32'(out_status), '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_removed_value !== want.value)
            flag_mismatch("removed_value", out_removed_value, want.value);
          if (out_removed_priority !== want.prio)
            flag_mismatch("removed_priority", 32'(out_removed_priority), 32'(want.prio));
          if (out_removed_position !== want.pos)
            flag_mismatch("removed_position", 32'(out_removed_position), 32'(want.pos));
          if (out_occupancy !== want.occ)
            flag_mismatch("occupancy", 32'(out_occupancy), 32'(want.occ));
          if (want.status == ST_FULL) n_full++;
          else if (want.status == ST_EMPTY) n_empty++;
          else if (want.prio !== 8'd0 || want.value !== 32'sd0 || want.pos !== 3'd0) n_removed++;
        end
        n_done <= n_done + 1;
        // long hold-off lets the core fill up and push back on the sender
        if (n_done + 1 == LONG_AT) stall_left = LONG_HOLD;
        else if (((n_done + 1) / 256) % 3 == 0) stall_left = 0;
        else stall_left = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("unsorted_array_priority_queue_core_tb: done, errors");
    $finish;
  end

  initial begin
    int bias;
    logic cmd;
    logic [7:0] p;
    int gap;

    // directed: empty remove, value and priority extremes, full drop, ties, last slot
    add_word(CMD_REMOVE, 32'sh1234_5678, 8'hff, 0, 1'b0);
    add_word(CMD_INSERT, 32'sh7fff_ffff, 8'd255, 0, 1'b0);
    add_word(CMD_INSERT, 32'sh8000_0000, 8'd0, 0, 1'b0);
    add_word(CMD_INSERT, 32'sd0, 8'd0, 0, 1'b0);
    add_word(CMD_INSERT, -32'sd1, 8'd128, 0, 1'b0);
    for (int k = 0; k < 4; k++) add_word(CMD_INSERT, k * 1000 + 1, 8'(200 + k), 0, 1'b0);
    add_word(CMD_INSERT, 32'sd99, 8'd1, 0, 1'b0);
    add_word(CMD_REMOVE, -32'sd1, 8'd0, 0, 1'b0);
    add_word(CMD_REMOVE, 32'sh7fff_ffff, 8'd255, 0, 1'b0);
    add_word(CMD_INSERT, 32'sd7, 8'd50, 0, 1'b0);
    add_word(CMD_INSERT, 32'sd8, 8'd0, 0, 1'b0);
    for (int k = 0; k < 8; k++)
      add_word(CMD_REMOVE, $urandom, 8'($urandom_range(0, 255)), 0, 1'b0);
    add_word(CMD_REMOVE, $urandom, 8'($urandom_range(0, 255)), 0, 1'b0);

    // random: insert share drifts so occupancy sweeps from empty to full
    bias = 50;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: bias = 90;
          1: bias = 10;
          default: bias = $urandom_range(30, 70);
        endcase
      end
      cmd = ($urandom_range(0, 99) < bias) ? CMD_INSERT : CMD_REMOVE;
      p = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      gap = ((i / 200) % 4 == 1) ? 0 : $urandom_range(0, 3);
      add_word(cmd, $urandom, p, gap, i == 700 || i == 1500);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid || n_sent != n_done) @(negedge clk);
    repeat (20) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, outcome_q.size());
      n_errors++;
    end

    $display("%0d words in, %0d checked: %0d pairs served, %0d inserts dropped full, %0d empty",
             n_sent, n_done, n_removed, n_full, n_empty);
    $display("random gaps and stalls, one %0d-cycle output hold-off, two drain pauses",
             LONG_HOLD);
    if (n_errors == 0) begin
      $display("unsorted_array_priority_queue_core_tb: done, clean");
    end else begin
      $display("unsorted_array_priority_queue_core_tb: done, errors");
    end
    $finish;
  end

endmodule
